// ===== hdl/lhp_pkg.sv =====
// Shared types and constants for the latency histogram percentile engine.
`timescale 1ns / 1ps
package lhp_pkg;

    localparam int TOP_BIN   = 4095;
    localparam int BIN_W     = $clog2(TOP_BIN + 1);
    localparam int COUNT_W   = 32;
    localparam int OUT_BIN_W = 12;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = ((3 * OUT_BIN_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    // ceil(2^k / d) with shift k, exact for any 32-bit dividend
    localparam logic [COUNT_W-1:0] MAG_HUNDRED  = 32'h51EB_851F;
    localparam int                 SH_HUNDRED   = 37;
    localparam logic [COUNT_W-1:0] MAG_THOUSAND = 32'h1062_4DD3;
    localparam int                 SH_THOUSAND  = 38;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_DIV100,
        ST_DIV1000,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic start;
        logic use_thousand;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hdl/lhp_cdiv.sv =====
// Reciprocal-multiply unit that divides the sample total by one hundred or one thousand.
`timescale 1ns / 1ps
module lhp_cdiv
    import lhp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    input  logic [COUNT_W-1:0] i_dividend,
    output t_div_rsp           o_rsp
);

    logic                 r_done;
    logic                 r_thousand;
    logic [2*COUNT_W-1:0] r_prod;
    logic [COUNT_W-1:0]   magic;

    // floor(n / d) = (n * ceil(2^k / d)) >> k; quotient is ready the cycle after start
    assign magic = i_req.use_thousand ? MAG_THOUSAND : MAG_HUNDRED;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod     <= {{COUNT_W{1'b0}}, i_dividend} * {{COUNT_W{1'b0}}, magic};
            r_thousand <= i_req.use_thousand;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_thousand ? COUNT_W'(r_prod[2*COUNT_W-1:SH_THOUSAND])
                                   : COUNT_W'(r_prod[2*COUNT_W-1:SH_HUNDRED]);

endmodule

// ===== hdl/lhp_bin_mem.sv =====
// Single-port bin count memory with registered read data.
`timescale 1ns / 1ps
module lhp_bin_mem
    import lhp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [BIN_W-1:0]   i_addr,
    input  logic [COUNT_W-1:0] i_wdata,
    output logic [COUNT_W-1:0] o_rdata
);

    logic [COUNT_W-1:0] r_mem [TOP_BIN + 1];
    logic [COUNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/latency_histogram_percentiles_core.sv =====
// Latency histogram percentile engine: top level with the control sequencer.
//
// Input channel (s): tuser is the action, 0 adds the latency sample in tdata,
// 1 queries the p50, p99 and p99.9 bins. Only a query makes a result word.
// Output channel (m): tuser is have_samples, tdata packs median, p99 and
// p99.9 bins, 12 bits each from bit 0 up.
// An add runs accept, read and write back through the single port
// of the 4096-entry bin memory; adds are dropped once the total is saturated.
// A query on an empty histogram goes from accept straight to the result
// state. Otherwise it runs two reciprocal multiplications of the total through
// one shared multiplier, then scans bins from 0 upward, each bin taking a
// memory read then an accumulate and compare, until all three thresholds are
// met or the top bin is scanned.
// s_tready is high only while the sequencer is idle. After reset the block
// clears all 4096 bin memory entries, one entry per cycle, with
// s_tready low. A finished result waits in the output register while m_tready
// is low; adds keep being taken meanwhile, and a later query holds its result
// until the output register frees.
`timescale 1ns / 1ps
module latency_histogram_percentiles_core
    import lhp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [31:0] sample_us
    input  logic                  i_s_tuser,   // [0] action
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [11:0] median_bin, [23:12] p99_bin,
                                               // [35:24] p999_bin, [39:36] zero
    output logic                  o_m_tuser    // [0] have_samples
);

    t_state             r_state, n_state;
    logic [BIN_W-1:0]   r_idx, n_idx;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [COUNT_W-1:0] r_run, n_run;
    logic [COUNT_W-1:0] r_th50, n_th50;
    logic [COUNT_W-1:0] r_th99, n_th99;
    logic [COUNT_W-1:0] r_th999, n_th999;
    logic [2:0]         r_hit, n_hit;
    logic [BIN_W-1:0]   r_b50, n_b50;
    logic [BIN_W-1:0]   r_b99, n_b99;
    logic [BIN_W-1:0]   r_b999, n_b999;
    logic               r_have, n_have;
    logic               r_m_valid;
    logic               r_m_have;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic               mem_we;
    logic [COUNT_W-1:0] mem_wdata;
    logic [COUNT_W-1:0] mem_rdata;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               load_out;
    logic [BIN_W-1:0]   clamp_idx;
    logic [COUNT_W-1:0] run_sum;

    lhp_bin_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (r_idx),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    lhp_cdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (r_total),
        .o_rsp      (div_rsp)
    );

    assign clamp_idx = (i_s_tdata > IN_DATA_W'(TOP_BIN)) ? BIN_W'(TOP_BIN)
                                                        : i_s_tdata[BIN_W-1:0];
    assign run_sum   = r_run + mem_rdata;
    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_total   = r_total;
        n_run     = r_run;
        n_th50    = r_th50;
        n_th99    = r_th99;
        n_th999   = r_th999;
        n_hit     = r_hit;
        n_b50     = r_b50;
        n_b99     = r_b99;
        n_b999    = r_b999;
        n_have    = r_have;
        mem_we    = 1'b0;
        mem_wdata = '0;
        div_req   = '0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_idx == BIN_W'(TOP_BIN)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser == ACT_ADD) begin
                        // drop the sample once the total is saturated
                        if (r_total != COUNT_MAX) begin
                            n_idx   = clamp_idx;
                            n_state = ST_ADD_RD;
                        end
                    end else if (r_total == '0) begin
                        n_have  = 1'b0;
                        n_b50   = '0;
                        n_b99   = '0;
                        n_b999  = '0;
                        n_state = ST_RESULT;
                    end else begin
                        div_req.start        = 1'b1;
                        div_req.use_thousand = 1'b0;
                        n_state              = ST_DIV100;
                    end
                end
            end
            ST_ADD_RD: begin
                n_state = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata + 1'b1;
                n_total   = r_total + 1'b1;
                n_state   = ST_IDLE;
            end
            ST_DIV100: begin
                if (div_rsp.done) begin
                    // ceil(99n/100) = n - floor(n/100)
                    n_th99               = r_total - div_rsp.quot;
                    div_req.start        = 1'b1;
                    div_req.use_thousand = 1'b1;
                    n_state              = ST_DIV1000;
                end
            end
            ST_DIV1000: begin
                if (div_rsp.done) begin
                    n_th999 = r_total - div_rsp.quot;
                    n_th50  = {1'b0, r_total[COUNT_W-1:1]} + COUNT_W'(r_total[0]);
                    n_run   = '0;
                    n_hit   = '0;
                    n_idx   = '0;
                    n_have  = 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_ACC;
            end
            ST_SCAN_ACC: begin
                n_run = run_sum;
                if (!r_hit[0] && (run_sum >= r_th50)) begin
                    n_hit[0] = 1'b1;
                    n_b50    = r_idx;
                end
                if (!r_hit[1] && (run_sum >= r_th99)) begin
                    n_hit[1] = 1'b1;
                    n_b99    = r_idx;
                end
                if (!r_hit[2] && (run_sum >= r_th999)) begin
                    n_hit[2] = 1'b1;
                    n_b999   = r_idx;
                end
                if ((&n_hit) || (r_idx == BIN_W'(TOP_BIN))) begin
                    n_state = ST_RESULT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (!r_m_valid || i_m_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_total   <= '0;
            r_hit     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_total <= n_total;
            r_hit   <= n_hit;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run   <= n_run;
        r_th50  <= n_th50;
        r_th99  <= n_th99;
        r_th999 <= n_th999;
        r_b50   <= n_b50;
        r_b99   <= n_b99;
        r_b999  <= n_b999;
        r_have  <= n_have;
        if (load_out) begin
            r_m_have <= r_have;
            r_m_data <= {(OUT_DATA_W - 3 * OUT_BIN_W)'(0),
                         OUT_BIN_W'(r_b999), OUT_BIN_W'(r_b99), OUT_BIN_W'(r_b50)};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_have;

endmodule

// ===== hdl/lhp_checker.sv =====
// Port-level checks for the latency histogram percentile engine, bound to the top level.
`timescale 1ns / 1ps
module lhp_checker
    import lhp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [IN_DATA_W-1:0]  i_s_tdata,
    input logic                  i_s_tuser,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tuser
);

    // reset drops any result and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && !o_s_tready))
        else $error("result or ready seen right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result word changed");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("empty histogram reported nonzero bins");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata[OUT_BIN_W-1:0] <= o_m_tdata[2*OUT_BIN_W-1:OUT_BIN_W]) &&
                        (o_m_tdata[2*OUT_BIN_W-1:OUT_BIN_W] <=
                         o_m_tdata[3*OUT_BIN_W-1:2*OUT_BIN_W])))
        else $error("percentile bins out of order");

    a_add_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == ACT_ADD) && !o_m_tvalid) |=> !o_m_tvalid)
        else $error("add word produced a result");

endmodule

bind latency_histogram_percentiles_core lhp_checker u_lhp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
